>>> src/olir_pkg.sv
// Shared types and constants of the ordered list block.
package olir_pkg;

   // Fixed field widths of the command and result beats
   localparam int FUNC_W   = 2;
   localparam int INDEX_W  = 7;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;
   localparam int LIMIT_W  = 7;

   // Reset value of the entry limit register
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   // Command codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

   // Shift control broadcast to every cell
   typedef struct packed {
      logic               ins;
      logic               rem;
      logic [INDEX_W-1:0] idx;
   } cell_ctrl_type;

endpackage

>>> src/olir_req_if.sv
// Command channel: valid/ready handshake with operation, position and payload word.
interface olir_req_if;
   logic                              valid;
   logic                              ready;
   logic [olir_pkg::FUNC_W-1:0]       func;
   logic [olir_pkg::INDEX_W-1:0]      index;
   logic [olir_pkg::WORD_W-1:0]       elem;

   modport source (output valid, output func, output index, output elem, input ready);
   modport sink   (input valid, input func, input index, input elem, output ready);
endinterface

>>> src/olir_rsp_if.sv
// Result channel: valid/ready handshake with status, read word, count and flags.
interface olir_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [olir_pkg::STATUS_W-1:0]     status;
   logic [olir_pkg::WORD_W-1:0]       read_data;
   logic [olir_pkg::COUNT_W-1:0]      count;
   logic                              is_full;
   logic                              is_empty;

   modport source (output valid, output status, output read_data, output count,
                   output is_full, output is_empty, input ready);
   modport sink   (input valid, input status, input read_data, input count,
                   input is_full, input is_empty, output ready);
endinterface

>>> src/olir_cell.sv
// One list cell: holds the entry at a fixed position and shifts with its neighbors.
module olir_cell #(
   parameter int ELEM_WIDTH = 32,
   parameter int POS        = 0
) (
   input  logic                        clock,
   input  olir_pkg::cell_ctrl_type     ctrl,
   input  logic [ELEM_WIDTH-1:0]       elem,
   input  logic [ELEM_WIDTH-1:0]       left_data,
   input  logic [ELEM_WIDTH-1:0]       right_data,
   output logic [ELEM_WIDTH-1:0]       data,
   output logic [ELEM_WIDTH-1:0]       hit_data
);

   logic [ELEM_WIDTH-1:0] cell_ff;
   logic [ELEM_WIDTH-1:0] cell_in;
   logic                  at_idx;
   logic                  above_idx;

   // Compare own position against the addressed position
   assign at_idx    = (32'(ctrl.idx) == POS);
   assign above_idx = (32'(ctrl.idx) < POS);

   // Take the new word, the lower neighbor on insert, the upper neighbor on remove
   always_comb begin
      cell_in = cell_ff;
      if (ctrl.ins) begin
         if (at_idx) begin
            cell_in = elem;
         end else if (above_idx) begin
            cell_in = left_data;
         end
      end else if (ctrl.rem) begin
         if (at_idx || above_idx) begin
            cell_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign data     = cell_ff;
   // Drive the entry onto the read tree only when addressed
   assign hit_data = at_idx ? cell_ff : '0;

endmodule

>>> src/olir_cell_row.sv
// Row of list cells with a registered OR tree that returns the addressed entry.
module olir_cell_row #(
   parameter int CAPACITY   = 64,
   parameter int ELEM_WIDTH = 32,
   parameter int GROUP      = 16
) (
   input  logic                        clock,
   input  olir_pkg::cell_ctrl_type     ctrl,
   input  logic [ELEM_WIDTH-1:0]       elem,
   output logic [ELEM_WIDTH-1:0]       read_data
);

   localparam int NGRP = (CAPACITY + GROUP - 1) / GROUP;

   logic [ELEM_WIDTH-1:0] data   [CAPACITY];
   logic [ELEM_WIDTH-1:0] hit    [NGRP*GROUP];
   logic [ELEM_WIDTH-1:0] grp_in [NGRP];
   logic [ELEM_WIDTH-1:0] grp_ff [NGRP];

   // Build the chain; the ends see zero from outside
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      olir_cell #(
         .ELEM_WIDTH (ELEM_WIDTH),
         .POS        (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .elem       (elem),
         .left_data  ((i == 0) ? '0 : data[(i == 0) ? 0 : i - 1]),
         .right_data ((i == CAPACITY - 1) ? '0 : data[(i == CAPACITY - 1) ? i : i + 1]),
         .data       (data[i]),
         .hit_data   (hit[i])
      );
   end

   // Pad the last group
   for (genvar i = CAPACITY; i < NGRP*GROUP; i++) begin : g_pad
      assign hit[i] = '0;
   end

   // First tree level: OR each group of cells
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GROUP; k++) begin
            grp_in[g] = grp_in[g] | hit[g*GROUP + k];
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   // Second tree level: OR the registered groups
   always_comb begin
      read_data = '0;
      for (int g = 0; g < NGRP; g++) begin
         read_data = read_data | grp_ff[g];
      end
   end

endmodule

>>> src/ordered_list_insert_remove.sv
// Top level of the ordered list: command decode, entry count, limit register and result stage.
//
//   channel   dir   handshake          payload
//   req_ch    in    valid / ready      func, index, elem
//   rsp_ch    out   valid / ready      status, read_data, count, is_full, is_empty
//   csr       in    csr_wr_en          csr_wr_data (entry limit)
//
// A command passes from its beat through decode into the command register, a shift state
// in which every cell shifts at once, and the registered OR tree that returns the
// addressed entry; no new command is taken until the last one has loaded its result.
// Reset clears the count and sets the limit to 64; cell contents are kept.
// A stalled result holds in the output register; the next command is accepted meanwhile
// and waits in the final stage until the output register frees.
module ordered_list_insert_remove #(
   parameter int CAPACITY   = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   olir_req_if.sink                        req_ch,
   olir_rsp_if.source                      rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [olir_pkg::LIMIT_W-1:0]    csr_wr_data
);

   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CW > olir_pkg::INDEX_W) ? CW : olir_pkg::INDEX_W;

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ} state_type;
   typedef enum logic [2:0] {OP_NONE, OP_INSERT, OP_REMOVE, OP_READ, OP_CLEAR} op_type;

   state_type                         state_ff;
   op_type                            op_ff;
   op_type                            op_in;
   logic [olir_pkg::STATUS_W-1:0]     status_ff;
   logic [olir_pkg::STATUS_W-1:0]     status_in;
   logic [olir_pkg::INDEX_W-1:0]      idx_ff;
   logic [ELEM_WIDTH-1:0]             elem_ff;
   logic [CW-1:0]                     count_ff;
   logic [CW-1:0]                     count_in;
   logic [olir_pkg::LIMIT_W-1:0]      limit_ff;
   logic                              rsp_valid_ff;
   logic [olir_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [olir_pkg::WORD_W-1:0]       rsp_data_ff;
   logic [olir_pkg::COUNT_W-1:0]      rsp_count_ff;
   logic                              rsp_full_ff;
   logic                              rsp_empty_ff;

   logic [CMP_W-1:0]                  idx_c;
   logic [CMP_W-1:0]                  cnt_c;
   logic [CMP_W-1:0]                  lim_c;
   logic [CMP_W-1:0]                  max_c;
   logic                              req_fire;
   logic                              rsp_free;
   olir_pkg::cell_ctrl_type           ctrl;
   logic [ELEM_WIDTH-1:0]             row_data;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // Clamp the limit register to 1 .. CAPACITY
   assign max_c = CMP_W'(limit_ff);
   always_comb begin
      if (limit_ff == '0) begin
         lim_c = CMP_W'(1);
      end else if (max_c > CMP_W'(CAPACITY)) begin
         lim_c = CMP_W'(CAPACITY);
      end else begin
         lim_c = max_c;
      end
   end

   assign idx_c = CMP_W'(req_ch.index);
   assign cnt_c = CMP_W'(count_ff);

   // Decode the command against the current count
   always_comb begin
      op_in     = OP_NONE;
      status_in = olir_pkg::ST_OK;
      case (req_ch.func)
         olir_pkg::FUNC_INSERT: begin
            if (idx_c > cnt_c) begin
               status_in = olir_pkg::ST_INVALID;
            end else if (cnt_c >= lim_c) begin
               status_in = olir_pkg::ST_FULL;
            end else begin
               op_in = OP_INSERT;
            end
         end
         olir_pkg::FUNC_REMOVE: begin
            if (idx_c > cnt_c) begin
               status_in = olir_pkg::ST_INVALID;
            end else if (cnt_c == '0) begin
               status_in = olir_pkg::ST_EMPTY;
            end else if (idx_c == cnt_c) begin
               status_in = olir_pkg::ST_INVALID;
            end else begin
               op_in = OP_REMOVE;
            end
         end
         olir_pkg::FUNC_READ: begin
            if (idx_c >= cnt_c) begin
               status_in = olir_pkg::ST_INVALID;
            end else begin
               op_in = OP_READ;
            end
         end
         default: begin
            op_in = OP_CLEAR;
         end
      endcase
   end

   // Next count after the shift cycle
   always_comb begin
      count_in = count_ff;
      if (state_ff == S_EXEC) begin
         case (op_ff)
            OP_INSERT: count_in = count_ff + CW'(1);
            OP_REMOVE: count_in = count_ff - CW'(1);
            OP_CLEAR:  count_in = '0;
            default:   count_in = count_ff;
         endcase
      end
   end

   // Broadcast the shift to the cells during the shift cycle only
   always_comb begin
      ctrl.ins = (state_ff == S_EXEC) && (op_ff == OP_INSERT);
      ctrl.rem = (state_ff == S_EXEC) && (op_ff == OP_REMOVE);
      ctrl.idx = idx_ff;
   end

   olir_cell_row #(
      .CAPACITY   (CAPACITY),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_row (
      .clock     (clock),
      .ctrl      (ctrl),
      .elem      (elem_ff),
      .read_data (row_data)
   );

   // Sequence the command and hold the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_NONE;
         count_ff     <= '0;
         limit_ff     <= olir_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         // Drop the taken result unless the final stage loads a new one this cycle
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != S_READ)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  op_ff     <= op_in;
                  status_ff <= status_in;
                  idx_ff    <= req_ch.index;
                  elem_ff   <= ELEM_WIDTH'(req_ch.elem);
                  state_ff  <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff <= S_READ;
            end
            S_READ: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_data_ff   <= (op_ff == OP_READ) ? olir_pkg::WORD_W'(row_data) : '0;
                  rsp_count_ff  <= olir_pkg::COUNT_W'(count_ff);
                  rsp_full_ff   <= (cnt_c >= lim_c);
                  rsp_empty_ff  <= (count_ff == '0);
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.read_data = rsp_data_ff;
   assign rsp_ch.count     = rsp_count_ff;
   assign rsp_ch.is_full   = rsp_full_ff;
   assign rsp_ch.is_empty  = rsp_empty_ff;

   // The count never passes the built capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_c <= CMP_W'(CAPACITY))
      else $error("entry count above capacity");

   // A full answer goes out with the full flag set
   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == olir_pkg::ST_FULL) |-> rsp_full_ff)
      else $error("full status without full flag");

   // Read data is nonzero only on a successful command
   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff != '0) |-> (rsp_status_ff == olir_pkg::ST_OK))
      else $error("read data on a failed command");

   // The count changes only in the cycle after the shift cycle
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_EXEC) |=> $stable(count_ff) || $past(reset))
      else $error("entry count changed outside the shift cycle");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the ordered list block, with a built-in list predictor.
`timescale 1ns / 1ps

module tb_top;

   localparam int LIST_DEPTH  = 64;
   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 200;

   typedef struct packed {
      logic [olir_pkg::STATUS_W-1:0] status;
      logic [olir_pkg::WORD_W-1:0]   read_data;
      logic [olir_pkg::COUNT_W-1:0]  count;
      logic                          is_full;
      logic                          is_empty;
   } list_result_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_wr_en;
   logic [olir_pkg::LIMIT_W-1:0]  csr_wr_data;

   olir_req_if req_bus ();
   olir_rsp_if rsp_bus ();

   ordered_list_insert_remove #(
      .CAPACITY   (LIST_DEPTH),
      .ELEM_WIDTH (olir_pkg::WORD_W)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predicted list contents and limit register
   logic [olir_pkg::WORD_W-1:0]   list_words [LIST_DEPTH];
   int                            list_len = 0;
   logic [olir_pkg::LIMIT_W-1:0]  limit_reg = olir_pkg::LIMIT_RESET;

   list_result_type     pending_results [$];
   int                  error_count = 0;
   int                  idle_cycles = 0;
   bit                  send_gaps_on = 1'b1;
   bit                  rsp_stalls_on = 1'b1;
   int                  rsp_hold = 0;

   // Free-running clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int effective_limit();
      int lim;
      lim = int'(limit_reg);
      if (lim < 1) lim = 1;
      if (lim > LIST_DEPTH) lim = LIST_DEPTH;
      return lim;
   endfunction

   // Apply one command to the predicted list and return its result beat
   function automatic list_result_type apply_command(logic [olir_pkg::FUNC_W-1:0] op,
                                                     logic [olir_pkg::INDEX_W-1:0] pos,
                                                     logic [olir_pkg::WORD_W-1:0] word);
      list_result_type res;
      int              p;
      p = int'(pos);
      res = '0;
      res.status = olir_pkg::ST_OK;
      case (op)
         olir_pkg::FUNC_INSERT: begin
            if (p > list_len) res.status = olir_pkg::ST_INVALID;
            else if (list_len >= effective_limit()) res.status = olir_pkg::ST_FULL;
            else begin
               for (int i = list_len; i > p; i--) list_words[i] = list_words[i-1];
               list_words[p] = word;
               list_len++;
            end
         end
         olir_pkg::FUNC_REMOVE: begin
            if (p > list_len) res.status = olir_pkg::ST_INVALID;
            else if (list_len == 0) res.status = olir_pkg::ST_EMPTY;
            else if (p == list_len) res.status = olir_pkg::ST_INVALID;
            else begin
               for (int i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
               list_len--;
            end
         end
         olir_pkg::FUNC_READ: begin
            if (p >= list_len) res.status = olir_pkg::ST_INVALID;
            else res.read_data = list_words[p];
         end
         default: begin
            list_len = 0;
         end
      endcase
      res.count    = list_len[olir_pkg::COUNT_W-1:0];
      res.is_full  = (list_len >= effective_limit());
      res.is_empty = (list_len == 0);
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= 100) $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   task automatic check_field(string what, logic [olir_pkg::WORD_W-1:0] got,
                              logic [olir_pkg::WORD_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", what, got, want));
   endtask

   // Offer one command beat and predict its result once accepted
   task automatic send_command(logic [olir_pkg::FUNC_W-1:0] op,
                               logic [olir_pkg::INDEX_W-1:0] pos,
                               logic [olir_pkg::WORD_W-1:0] word);
      int gap;
      gap = send_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.func  <= op;
      req_bus.index <= pos;
      req_bus.elem  <= word;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(apply_command(op, pos, word));
   endtask

   // Drop valid, then wait for every pending result
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_limit(logic [olir_pkg::LIMIT_W-1:0] value);
      drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      limit_reg    = value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly well-formed commands around the current list size, some noise
   task automatic random_command(int ins_pct);
      int                          r;
      int                          pos;
      int                          top;
      logic [olir_pkg::FUNC_W-1:0] op;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         op  = olir_pkg::FUNC_W'($urandom_range(0, 3));
         pos = $urandom_range(0, 127);
      end else begin
         r = $urandom_range(0, 99);
         if (r < ins_pct) op = olir_pkg::FUNC_INSERT;
         else if (r < ins_pct + 25) op = olir_pkg::FUNC_REMOVE;
         else if (r < 99) op = olir_pkg::FUNC_READ;
         else op = olir_pkg::FUNC_CLEAR;
         top = (op == olir_pkg::FUNC_INSERT) ? list_len : list_len - 1;
         r = $urandom_range(0, 99);
         if (r < 6) pos = list_len + 1;
         else if (r < 12) pos = list_len;
         else if (r < 18 || top < 0) pos = 0;
         else pos = $urandom_range(0, top);
      end
      send_command(op, pos[olir_pkg::INDEX_W-1:0], $urandom());
   endtask

   task automatic run_phase(logic [olir_pkg::LIMIT_W-1:0] lim, int n, int ins_pct, bit gaps,
                            bit stalls);
      set_limit(lim);
      send_gaps_on  = gaps;
      rsp_stalls_on = stalls;
      repeat (n) random_command(ins_pct);
   endtask

   // Edge cases of every operation at the reset limit
   task automatic test_directed_cases();
      send_command(olir_pkg::FUNC_READ,   7'd0,   $urandom());
      send_command(olir_pkg::FUNC_REMOVE, 7'd0,   $urandom());
      send_command(olir_pkg::FUNC_REMOVE, 7'd3,   $urandom());
      send_command(olir_pkg::FUNC_REMOVE, 7'd127, $urandom());
      send_command(olir_pkg::FUNC_INSERT, 7'd1,   32'h1234_5678);
      send_command(olir_pkg::FUNC_INSERT, 7'd0,   32'hFFFF_FFFF);
      send_command(olir_pkg::FUNC_INSERT, 7'd0,   32'h0000_0000);
      send_command(olir_pkg::FUNC_INSERT, 7'd2,   32'h8000_0001);
      send_command(olir_pkg::FUNC_INSERT, 7'd1,   32'h5A5A_A5A5);
      for (int i = 0; i < 4; i++)
         send_command(olir_pkg::FUNC_READ, i[olir_pkg::INDEX_W-1:0], $urandom());
      send_command(olir_pkg::FUNC_READ,   7'd4,   $urandom());
      send_command(olir_pkg::FUNC_READ,   7'd127, $urandom());
      send_command(olir_pkg::FUNC_REMOVE, 7'd4,   $urandom());
      send_command(olir_pkg::FUNC_INSERT, 7'd5,   $urandom());
      send_command(olir_pkg::FUNC_REMOVE, 7'd1,   $urandom());
      send_command(olir_pkg::FUNC_REMOVE, 7'd2,   $urandom());
      send_command(olir_pkg::FUNC_READ,   7'd1,   $urandom());
      send_command(olir_pkg::FUNC_CLEAR,  7'd127, $urandom());
      send_command(olir_pkg::FUNC_CLEAR,  7'd0,   $urandom());
      send_command(olir_pkg::FUNC_INSERT, 7'd127, $urandom());
      send_command(olir_pkg::FUNC_READ,   7'd0,   $urandom());
   endtask

   // Smallest and largest limits, including values that clamp
   task automatic test_limit_extremes();
      set_limit(7'd0);
      send_command(olir_pkg::FUNC_INSERT, 7'd0, $urandom());
      send_command(olir_pkg::FUNC_INSERT, 7'd0, $urandom());
      send_command(olir_pkg::FUNC_INSERT, 7'd2, $urandom());
      send_command(olir_pkg::FUNC_READ,   7'd0, $urandom());
      send_command(olir_pkg::FUNC_REMOVE, 7'd0, $urandom());
      send_command(olir_pkg::FUNC_REMOVE, 7'd0, $urandom());
      set_limit(7'd1);
      send_command(olir_pkg::FUNC_INSERT, 7'd0, $urandom());
      send_command(olir_pkg::FUNC_INSERT, 7'd1, $urandom());
      send_command(olir_pkg::FUNC_CLEAR,  7'd0, $urandom());
      set_limit(7'd127);
      while (list_len < LIST_DEPTH)
         send_command(olir_pkg::FUNC_INSERT, 7'($urandom_range(0, list_len)), $urandom());
      send_command(olir_pkg::FUNC_INSERT, 7'd0,  $urandom());
      send_command(olir_pkg::FUNC_INSERT, 7'd64, $urandom());
      repeat (8)
         send_command(olir_pkg::FUNC_READ, 7'($urandom_range(0, LIST_DEPTH - 1)), $urandom());
      send_command(olir_pkg::FUNC_READ,   7'd63, $urandom());
      send_command(olir_pkg::FUNC_REMOVE, 7'd63, $urandom());
      send_command(olir_pkg::FUNC_CLEAR,  7'd0,  $urandom());
   endtask

   // Limit lowered under the current count
   task automatic test_limit_below_count();
      set_limit(7'd64);
      repeat (12)
         send_command(olir_pkg::FUNC_INSERT, 7'($urandom_range(0, list_len)), $urandom());
      set_limit(7'd5);
      send_command(olir_pkg::FUNC_INSERT, 7'd0,  $urandom());
      send_command(olir_pkg::FUNC_INSERT, 7'd13, $urandom());
      repeat (3)
         send_command(olir_pkg::FUNC_READ, 7'($urandom_range(0, list_len - 1)), $urandom());
      while (list_len > 4)
         send_command(olir_pkg::FUNC_REMOVE, 7'($urandom_range(0, list_len - 1)), $urandom());
      send_command(olir_pkg::FUNC_INSERT, 7'd2, $urandom());
      send_command(olir_pkg::FUNC_INSERT, 7'd0, $urandom());
      set_limit(7'd65);
      send_command(olir_pkg::FUNC_INSERT, 7'd5, $urandom());
   endtask

   // Random traffic across several limits and idling mixes
   task automatic test_random_traffic();
      run_phase(7'd64,  200, 60, 1'b1, 1'b1);
      run_phase(7'd3,   120, 40, 1'b1, 1'b1);
      run_phase(7'd127, 180, 55, 1'b0, 1'b0);
      run_phase(7'd0,   100, 45, 1'b1, 1'b1);
      run_phase(7'($urandom_range(2, 63)), 150, 50, 1'b1, 1'b0);
      run_phase(7'd65,  130, 20, 1'b0, 1'b1);
      send_gaps_on  = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // Hold the result side off while commands keep coming, so the input stalls
   task automatic test_output_stall();
      send_gaps_on = 1'b0;
      rsp_hold     = HOLD_CYCLES;
      repeat (30) random_command(50);
      send_gaps_on = 1'b1;
   endtask

   // Result receiver: random stalls, plus long hold-off on request
   initial begin : result_receiver
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold--;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (rsp_stalls_on && $urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                       : $urandom_range(8, 30);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compare each result beat with the oldest prediction
   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result beat with no command pending");
         end else begin
            want = pending_results.pop_front();
            check_field("status",    olir_pkg::WORD_W'(rsp_bus.status),
                        olir_pkg::WORD_W'(want.status));
            check_field("read_data", rsp_bus.read_data, want.read_data);
            check_field("count",     olir_pkg::WORD_W'(rsp_bus.count),
                        olir_pkg::WORD_W'(want.count));
            check_field("is_full",   olir_pkg::WORD_W'(rsp_bus.is_full),
                        olir_pkg::WORD_W'(want.is_full));
            check_field("is_empty",  olir_pkg::WORD_W'(rsp_bus.is_empty),
                        olir_pkg::WORD_W'(want.is_empty));
         end
      end
   end

   // Watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.func  = olir_pkg::FUNC_INSERT;
      req_bus.index = '0;
      req_bus.elem  = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_limit_extremes();
      test_limit_below_count();
      test_random_traffic();
      test_output_stall();

      // Drain, then let any stray beat show up
      drain();
      repeat (8) @(posedge clock);
      if (error_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
